// ===== src/fps_pkg.sv =====
// Package for the binary indexed prefix-sum table: request and result types,
// operation and state codes, and fixed field widths. No dependencies.
`default_nettype none

package fps_pkg;

  // Fixed field widths.
  localparam int IDX_W   = 11;
  localparam int POS_W   = IDX_W + 1;
  localparam int DELTA_W = 16;
  localparam int SUM_W   = 32;
  localparam int OP_W    = 2;

  // Size register value after reset.
  localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(1024);

  // Operation codes carried in a request.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_PREFIX = 2'd1,
    OP_RANGE  = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // One input request.
  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [IDX_W-1:0]          index;
    logic [IDX_W-1:0]          left_index;
    logic signed [DELTA_W-1:0] delta;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    status;
  } res_t;

  // Finished result offered by the controller to the output register.
  typedef struct packed {
    logic valid;
    res_t res;
  } done_t;

endpackage

`default_nettype wire

// ===== src/fps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the written address
  // returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/fps_ctrl.sv =====
// Controller of the prefix-sum table: clearing pass, request checks, and the
// index-chain walks that read, modify and write the partial-sum RAM.
// Depends on fps_pkg.
`default_nettype none

module fps_ctrl
  import fps_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [IDX_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire in_req_t                       in_data,
  input  wire logic                          slot_free,
  output done_t                              done,
  output logic                               ram_we,
  output logic      [$clog2(TABLE_SIZE)-1:0] ram_waddr,
  output logic      [SUM_W-1:0]              ram_wdata,
  output logic      [$clog2(TABLE_SIZE)-1:0] ram_raddr,
  input  wire logic [SUM_W-1:0]              ram_rdata
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int CAP = (TABLE_SIZE > 2047) ? 2047 : TABLE_SIZE;
  localparam logic [IDX_W-1:0] CAP_V    = IDX_W'(CAP);
  localparam logic [AW-1:0]    LAST_ADR = AW'(TABLE_SIZE - 1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  size_reg;
  logic [IDX_W-1:0]  limit, limit_next;
  logic [OP_W-1:0]   op, op_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  left_m1, left_m1_next;
  logic              second, second_next;
  logic [SUM_W-1:0]  delta_ext, delta_ext_next;
  logic [SUM_W-1:0]  acc, acc_next;
  logic              status, status_next;
  logic              pend_valid, pend_valid_next;
  logic              pend_sub, pend_sub_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;

  logic [IDX_W-1:0]  eff_size;
  logic              req_err;
  logic [POS_W-1:0]  lowbit;
  logic [AW-1:0]     pos_addr;
  logic              walk_live;

  // Effective size is the register clamped to the table depth.
  assign eff_size = (size_reg > CAP_V) ? CAP_V : size_reg;

  // Range checks on a new request.
  always_comb begin
    unique case (in_data.operation)
      OP_ADD:    req_err = (in_data.index == '0) || (in_data.index > eff_size);
      OP_PREFIX: req_err = (in_data.index > eff_size);
      OP_RANGE:  req_err = (in_data.index > eff_size) || (in_data.left_index == '0) ||
                           (in_data.left_index > eff_size);
      default:   req_err = 1'b1;
    endcase
  end

  // Walk step helpers: lowest set bit and RAM address of the current node.
  assign lowbit   = pos & (~pos + POS_W'(1));
  assign pos_addr = AW'(pos - POS_W'(1));
  assign walk_live = (op == OP_ADD) ? ((pos != '0) && (pos <= {1'b0, limit}))
                                    : (pos != '0);

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_wen) begin
      size_reg <= cfg_wdata;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      pend_valid <= 1'b0;
      clr_addr   <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      clr_addr   <= clr_addr_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    limit     <= limit_next;
    op        <= op_next;
    pos       <= pos_next;
    left_m1   <= left_m1_next;
    second    <= second_next;
    delta_ext <= delta_ext_next;
    acc       <= acc_next;
    status    <= status_next;
    pend_sub  <= pend_sub_next;
    pend_addr <= pend_addr_next;
  end

  // Next state, walk sequencing and RAM access.
  always_comb begin
    state_next      = state;
    limit_next      = limit;
    op_next         = op;
    pos_next        = pos;
    left_m1_next    = left_m1;
    second_next     = second;
    delta_ext_next  = delta_ext;
    acc_next        = acc;
    status_next     = status;
    pend_valid_next = 1'b0;
    pend_sub_next   = pend_sub;
    pend_addr_next  = pend_addr;
    clr_addr_next   = clr_addr;
    in_stall        = 1'b1;
    done.valid      = 1'b0;
    done.res.sum    = acc;
    done.res.status = status;
    ram_we          = 1'b0;
    ram_waddr       = pend_addr;
    ram_wdata       = ram_rdata + delta_ext;
    ram_raddr       = pos_addr;

    unique case (state)
      // Zero the RAM one word per cycle after reset.
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADR) begin
          state_next = ST_IDLE;
        end
      end

      // Take a request and check its indexes.
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_next        = in_data.operation;
          limit_next     = eff_size;
          pos_next       = {1'b0, in_data.index};
          left_m1_next   = {1'b0, in_data.left_index} - POS_W'(1);
          second_next    = 1'b0;
          delta_ext_next = {{(SUM_W-DELTA_W){in_data.delta[DELTA_W-1]}}, in_data.delta};
          acc_next       = '0;
          status_next    = req_err;
          state_next     = req_err ? ST_DONE : ST_WALK;
        end
      end

      // One node per cycle: retire the read issued last cycle, issue the next.
      ST_WALK: begin
        if (pend_valid) begin
          if (op == OP_ADD) begin
            ram_we = 1'b1;
          end else begin
            acc_next = pend_sub ? (acc - ram_rdata) : (acc + ram_rdata);
          end
        end
        if (walk_live) begin
          pend_valid_next = 1'b1;
          pend_addr_next  = pos_addr;
          pend_sub_next   = second;
          pos_next        = (op == OP_ADD) ? (pos + lowbit) : (pos - lowbit);
        end else if ((op == OP_RANGE) && !second) begin
          second_next = 1'b1;
          pos_next    = left_m1;
        end else begin
          state_next = ST_DONE;
        end
      end

      // Hand the result to the output register.
      ST_DONE: begin
        done.valid = 1'b1;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fenwick_prefix_sum_table_core.sv =====
// Top level of the binary indexed prefix-sum table: controller, partial-sum
// RAM and output register. Depends on fps_pkg, fps_ctrl and fps_ram.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request: point
//   add, prefix query or range query. Output channel out_valid / out_stall /
//   out_data returns exactly one result per request, in order.
//   cfg_wen / cfg_wdata write the active size; write it only while idle.
// Operation:
//   One request is worked on at a time. Each tree node costs one RAM
//   read, with the write-back of an add overlapped with the next read.
//   A request walks the nodes on its index chain; a range query walks two
//   chains and switches between them, and a rejected request goes straight
//   to the output register. The next request is taken in the cycle after
//   the result enters the register. The single read port of the
//   partial-sum RAM limits the walk to one node read at a time.
// Reset:
//   rst is synchronous. After it, in_stall stays high while the RAM is
//   cleared; the size register returns to 1024.
// Stall:
//   A result waits in the output register while out_stall is high. The next
//   request is still taken and worked on; it finishes into the register once
//   the waiting result has gone.
`default_nettype none

module fenwick_prefix_sum_table_core
  import fps_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_req_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output res_t                  out_data
);

  localparam int AW = $clog2(TABLE_SIZE);

  done_t            done;
  logic             slot_free;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  fps_ctrl #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .slot_free (slot_free),
    .done      (done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  fps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid || !out_stall;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done.valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (done.valid && slot_free) begin
      out_data <= done.res;
    end
  end

endmodule

`default_nettype wire

// ===== src/fps_checker.sv =====
// Port-level checker for the prefix-sum table, bound to the top level.
// Depends on fps_pkg and fenwick_prefix_sum_table_core.
`default_nettype none

module fps_checker
  import fps_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire res_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // The clearing pass holds off requests once reset is released.
  a_rst_clear: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("request accepted during clearing pass");

  // One request at a time: an accepted request blocks the next cycle.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

  // A rejected request never carries a sum.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.sum == '0)
    else $error("nonzero sum with error status");

endmodule

bind fenwick_prefix_sum_table_core fps_checker u_fps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/fps_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the binary indexed prefix-sum table. It keeps its own copy of the
// partial sums and the size register, predicts each result and compares the results in order.
// Depends on fps_pkg only.

module fps_result_checker
  import fps_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_req_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  res_t             out_data,
  output int               pending,
  output int               fail_count
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the tree nodes (1-based, as in the tree walk) and of the size.
  logic [SUM_W-1:0] node_sum [1:TABLE_SIZE];
  logic [IDX_W-1:0] size_reg;
  res_t             result_q [$];
  int               error_count = 0;

  // The size in force is capped at the table depth.
  function automatic int size_in_force();
    return (int'(size_reg) > TABLE_SIZE) ? TABLE_SIZE : int'(size_reg);
  endfunction

  // Walk down the index chain and add up the nodes it passes.
  function automatic logic [SUM_W-1:0] chain_sum(int pos);
    logic [SUM_W-1:0] acc;
    acc = '0;
    while (pos > 0) begin
      if (pos <= TABLE_SIZE) acc += node_sum[pos];
      pos -= pos & (-pos);
    end
    return acc;
  endfunction

  // Walk up the index chain, stopping at the size that is in force now.
  function automatic void chain_add(int pos, logic [SUM_W-1:0] amount, int limit);
    while (pos >= 1 && pos <= limit) begin
      node_sum[pos] += amount;
      pos += pos & (-pos);
    end
  endfunction

  // Work out the result of one request and apply any add to the shadow table.
  function automatic res_t predict_result(in_req_t r);
    res_t             res;
    int               n;
    logic [SUM_W-1:0] amount;
    n = size_in_force();
    amount = {{(SUM_W-DELTA_W){r.delta[DELTA_W-1]}}, r.delta};
    res.sum = '0;
    res.status = 1'b0;
    case (r.operation)
      OP_ADD: begin
        if (r.index == 0 || r.index > n) res.status = 1'b1;
        else chain_add(r.index, amount, n);
      end
      OP_PREFIX: begin
        if (r.index > n) res.status = 1'b1;
        else res.sum = chain_sum(r.index);
      end
      OP_RANGE: begin
        if (r.index > n || r.left_index == 0 || r.left_index > n) res.status = 1'b1;
        else res.sum = chain_sum(r.index) - chain_sum(int'(r.left_index) - 1);
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  // Compare each accepted result first, then record the size write and the new request.
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (rst) begin
      for (int i = 1; i <= TABLE_SIZE; i++) node_sum[i] = '0;
      size_reg = SIZE_RESET;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("%0t: result with none expected: sum %0d status %0b",
                     $time, out_data.sum, out_data.status);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.sum !== want.sum || out_data.status !== want.status) begin
            if (error_count < REPORT_LIMIT)
              $display("%0t: result differs: expected sum %0d status %0b, got sum %0d status %0b",
                       $time, want.sum, want.status, out_data.sum, out_data.status);
            error_count++;
          end
        end
      end
      if (cfg_wen) size_reg = cfg_wdata;
      if (in_valid && !in_stall) result_q.push_back(predict_result(in_data));
    end
    pending <= result_q.size();
    fail_count <= error_count;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the prefix-sum table testbench: clock, reset, request and size stimulus, and
// random result stall. Depends on fps_pkg, fenwick_prefix_sum_table_core and fps_result_checker.

module tb;
  import fps_pkg::*;

  localparam int              TABLE_SIZE    = 1024;
  localparam int              SETTLE_CYCLES = 30;
  localparam int              RUN_LIMIT_NS  = 13_000_000;
  localparam int              MAX_INDEX     = 2**IDX_W - 1;
  localparam int              PHASES        = 8;
  localparam logic [OP_W-1:0] OP_UNKNOWN    = 2'd3;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_wen   = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  in_req_t          in_data   = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  res_t             out_data;
  int               pending;
  int               fail_count;

  // Idling controls; each phase switches them.
  bit tx_gaps_on  = 1'b0;
  bit rx_stall_on = 1'b0;
  int stall_left  = 0;
  int size_now    = TABLE_SIZE;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fenwick_prefix_sum_table_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  fps_result_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // An index meant to be rejected: zero (rejected as an add index or a range's left index) or above the size.
  function automatic logic [IDX_W-1:0] rejected_index(int n);
    if ($urandom_range(0, 1) == 0) return '0;
    return IDX_W'($urandom_range(n + 1, MAX_INDEX));
  endfunction

  function automatic in_req_t build_request(logic [OP_W-1:0] op, int idx, int left,
                                            logic [DELTA_W-1:0] d);
    in_req_t r;
    r.operation  = op;
    r.index      = IDX_W'(idx);
    r.left_index = IDX_W'(left);
    r.delta      = d;
    return r;
  endfunction

  // Mostly well-formed requests inside the size, with a tenth of rejected indexes.
  function automatic in_req_t random_request(int n);
    in_req_t r;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.operation = OP_ADD;
    else if (pick < 70) r.operation = OP_PREFIX;
    else if (pick < 95) r.operation = OP_RANGE;
    else r.operation = OP_UNKNOWN;
    if (n > 0 && $urandom_range(0, 9) != 0) r.index = IDX_W'($urandom_range(1, n));
    else r.index = rejected_index(n);
    if (n > 0 && $urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 4) != 0 && r.index != 0 && r.index <= n)
        r.left_index = IDX_W'($urandom_range(1, r.index));
      else
        r.left_index = IDX_W'($urandom_range(1, n));
    end else begin
      r.left_index = rejected_index(n);
    end
    if ($urandom_range(0, 9) == 0)
      r.delta = ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
    else
      r.delta = DELTA_W'($urandom);
    return r;
  endfunction

  // Offer one request, after an optional gap, and hold it until it is taken.
  task automatic send_request(in_req_t r);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off new requests until every result is back and the block has settled.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [IDX_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    size_now = (int'(value) > TABLE_SIZE) ? TABLE_SIZE : int'(value);
  endtask

  // Random stall on the result side.
  always @(posedge clk) begin
    if (!rx_stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_length();
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int phase_size [PHASES];
    phase_size[0] = 1;
    phase_size[1] = MAX_INDEX;
    phase_size[2] = 0;
    phase_size[3] = 16;
    phase_size[4] = $urandom_range(2, TABLE_SIZE - 1);
    phase_size[5] = TABLE_SIZE;
    phase_size[6] = $urandom_range(100, TABLE_SIZE - 1);
    phase_size[7] = 2;

    repeat (2) @(posedge clk);
    rst         <= 1'b0;
    tx_gaps_on  <= 1'b1;
    rx_stall_on <= 1'b1;

    // Directed requests at the reset size: extremes, every operation, rejected indexes.
    send_request(build_request(OP_ADD, 1, 1, 16'h7FFF));
    send_request(build_request(OP_ADD, TABLE_SIZE, 1, 16'h8000));
    send_request(build_request(OP_ADD, 0, 1, 16'h0005));
    send_request(build_request(OP_ADD, TABLE_SIZE + 1, 1, 16'h0001));
    send_request(build_request(OP_ADD, MAX_INDEX, MAX_INDEX, 16'hFFFF));
    send_request(build_request(OP_ADD, 682, 341, 16'h5555));
    send_request(build_request(OP_ADD, 341, 682, 16'hAAAA));
    send_request(build_request(OP_ADD, 3, 1, 16'h0000));
    send_request(build_request(OP_PREFIX, 0, 0, 16'h0000));
    send_request(build_request(OP_PREFIX, TABLE_SIZE, 1, 16'h0000));
    send_request(build_request(OP_PREFIX, TABLE_SIZE - 1, 1, 16'h0000));
    send_request(build_request(OP_PREFIX, TABLE_SIZE + 1, 1, 16'h0000));
    send_request(build_request(OP_PREFIX, MAX_INDEX, 1, 16'hFFFF));
    send_request(build_request(OP_RANGE, TABLE_SIZE, 1, 16'h0000));
    send_request(build_request(OP_RANGE, 700, 700, 16'h0000));
    send_request(build_request(OP_RANGE, 0, 1, 16'h0000));
    send_request(build_request(OP_RANGE, 500, 0, 16'h0000));
    send_request(build_request(OP_RANGE, 500, TABLE_SIZE + 1, 16'h0000));
    send_request(build_request(OP_RANGE, 500, MAX_INDEX, 16'h0000));
    send_request(build_request(OP_RANGE, 3, 900, 16'h0000));
    send_request(build_request(OP_RANGE, TABLE_SIZE + 1, 1, 16'h0000));
    send_request(build_request(OP_UNKNOWN, 5, 1, 16'h1234));
    wait_for_results();

    // Random phases, each under its own size and idling mix; the store carries over.
    for (int p = 0; p < PHASES; p++) begin
      write_size(IDX_W'(phase_size[p]));
      tx_gaps_on  <= (p % 3 != 1);
      rx_stall_on <= (p % 3 != 2);
      repeat ((phase_size[p] == 0) ? 40 : 100) send_request(random_request(size_now));
      wait_for_results();
    end

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
